[src/ssdl_pkg.sv]
`default_nettype none
package ssdl_pkg;

    localparam int SHORT_TAPS  = 32;
    localparam int WINDOW_TAPS = 256;
    localparam int SAMPLE_BITS = 12;
    localparam int SHORT_AW    = $clog2(SHORT_TAPS);
    localparam int WINDOW_AW   = $clog2(WINDOW_TAPS);
    localparam int CNT_W       = WINDOW_AW + 1;
    localparam int SUM_W       = SAMPLE_BITS + SHORT_AW;
    localparam int DUTY_W      = 16;
    localparam int CFG_IDX_W   = 3;

    localparam logic [2:0] MID_STEPS_MAX = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_UNSTABLE_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_LEVEL  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_LEVEL      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR_LOW = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR_MID = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_FULL      = 3'd6;

    localparam logic [1:0] ZONE_HIGH = 2'd0;
    localparam logic [1:0] ZONE_MID  = 2'd1;
    localparam logic [1:0] ZONE_DEEP = 2'd2;
    localparam logic [1:0] ZONE_NONE = 2'd3;

    typedef struct packed {
        logic                 load;
        logic                 fill;
        logic                 fill_short;
        logic                 rd_short;
        logic                 upd_short;
        logic                 wr_win;
        logic                 scan_rd;
        logic                 scan_acc;
        logic                 decide;
        logic [WINDOW_AW-1:0] addr;
    } cmd_t;

    typedef struct packed {
        logic primed;
        logic out_busy;
    } status_t;

endpackage
`default_nettype wire

[src/supply_sag_duty_limiter.sv]
// Supply sag duty limiter. Each sample transaction updates a 32-entry averaging
// ring and a 256-entry window ring, finds the window's max and min, and moves a
// PWM duty ceiling by voltage zone. An item passes from accept to result through
// a ring read, ring update and window write, then a scan of the window memory,
// one entry a cycle, and the decision, which waits while a stalled result is
// held; the first item after reset instead fills both rings with its sample
// before the window write. Configuration writes take effect at once and belong
// only to idle periods.
`default_nettype none
module supply_sag_duty_limiter (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire [11:0]  sample,
    input  wire         add_tick,
    input  wire         sub_tick,
    input  wire         cfg_we,
    input  wire [2:0]   cfg_index,
    input  wire [15:0]  cfg_data,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [15:0] duty_limit,
    output logic [11:0] filtered_level,
    output logic [11:0] window_range,
    output logic        unstable,
    output logic [1:0]  zone
);

    ssdl_pkg::cmd_t    cmd;
    ssdl_pkg::status_t status;

    ssdl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    ssdl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (sample),
        .add_tick       (add_tick),
        .sub_tick       (sub_tick),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .duty_limit     (duty_limit),
        .filtered_level (filtered_level),
        .window_range   (window_range),
        .unstable       (unstable),
        .zone           (zone)
    );

endmodule
`default_nettype wire

[src/ssdl_ctrl.sv]
`default_nettype none
module ssdl_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_stall,
    input  ssdl_pkg::status_t   status,
    output ssdl_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_UPD  = 3'd3;
    localparam logic [2:0] ST_WRW  = 3'd4;
    localparam logic [2:0] ST_SCAN = 3'd5;
    localparam logic [2:0] ST_DEC  = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic [ssdl_pkg::CNT_W-1:0] cnt_reg, cnt_next;

    assign in_stall = (state_reg != ST_IDLE);

    // sequence one transaction through fill, ring update, window scan and decision
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.addr   = cnt_reg[ssdl_pkg::WINDOW_AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = status.primed ? ST_RD : ST_FILL;
                end
            end
            ST_FILL:
            begin
                cmd.fill       = 1'b1;
                cmd.fill_short = (cnt_reg < ssdl_pkg::CNT_W'(ssdl_pkg::SHORT_TAPS));
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == ssdl_pkg::CNT_W'(ssdl_pkg::WINDOW_TAPS - 1))
                begin
                    state_next = ST_WRW;
                end
            end
            ST_RD:
            begin
                cmd.rd_short = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD:
            begin
                cmd.upd_short = 1'b1;
                state_next    = ST_WRW;
            end
            ST_WRW:
            begin
                cmd.wr_win = 1'b1;
                cnt_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_rd  = (cnt_reg != ssdl_pkg::CNT_W'(ssdl_pkg::WINDOW_TAPS));
                cmd.scan_acc = (cnt_reg != '0);
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == ssdl_pkg::CNT_W'(ssdl_pkg::WINDOW_TAPS))
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                if (!status.out_busy)
                begin
                    cmd.decide = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[src/ssdl_dp.sv]
`default_nettype none
module ssdl_dp (
    input  wire                   clk,
    input  wire                   rst_n,
    input  ssdl_pkg::cmd_t        cmd,
    output ssdl_pkg::status_t     status,
    input  wire [11:0]            sample,
    input  wire                   add_tick,
    input  wire                   sub_tick,
    input  wire                   cfg_we,
    input  wire [2:0]             cfg_index,
    input  wire [15:0]            cfg_data,
    output logic                  out_valid,
    input  wire                   out_stall,
    output logic [15:0]           duty_limit,
    output logic [11:0]           filtered_level,
    output logic [11:0]           window_range,
    output logic                  unstable,
    output logic [1:0]            zone
);

    localparam int SB = ssdl_pkg::SAMPLE_BITS;
    localparam int DW = ssdl_pkg::DUTY_W;

    logic [SB-1:0] short_mem [ssdl_pkg::SHORT_TAPS];
    logic [SB-1:0] win_mem   [ssdl_pkg::WINDOW_TAPS];

    logic [SB-1:0] unstable_range_reg, nominal_level_reg, dead_zone_reg, low_level_reg;
    logic [DW-1:0] duty_floor_low_reg, duty_floor_mid_reg, duty_full_reg;

    logic                          primed_reg;
    logic [ssdl_pkg::SHORT_AW-1:0] short_pos_reg;
    logic [ssdl_pkg::WINDOW_AW-1:0] win_pos_reg;
    logic [2:0]                    mid_steps_reg, mid_steps_next;
    logic                          deep_reg, deep_next;
    logic                          pend_up_reg, pend_up_next;
    logic                          pend_dn_reg, pend_dn_next;
    logic [DW-1:0]                 duty_reg, duty_next;
    logic [ssdl_pkg::SUM_W-1:0]    sum_reg;
    logic [SB-1:0]                 sample_reg, short_q_reg, win_q_reg, max_reg, min_reg;
    logic                          out_valid_reg;
    logic [DW-1:0]                 o_duty_reg;
    logic [SB-1:0]                 o_avg_reg, o_range_reg;
    logic                          o_unst_reg;
    logic [1:0]                    o_zone_reg, zone_next;

    logic [SB-1:0] avg, range_v, new_slot;
    logic          unst;
    logic [SB:0]   high_thr;
    logic [DW-1:0] duty_m2;

    assign avg      = sum_reg[ssdl_pkg::SUM_W-1:ssdl_pkg::SHORT_AW];
    assign new_slot = SB'(({1'b0, short_q_reg} + {1'b0, sample_reg}) >> 1);
    assign range_v  = max_reg - min_reg;
    assign unst     = range_v > unstable_range_reg;
    assign high_thr = {1'b0, nominal_level_reg} + {1'b0, dead_zone_reg};
    assign duty_m2  = (duty_reg > DW'(2)) ? duty_reg - DW'(2) : '0;

    assign status.primed   = primed_reg;
    assign status.out_busy = out_valid_reg && out_stall;

    assign out_valid      = out_valid_reg;
    assign duty_limit     = o_duty_reg;
    assign filtered_level = o_avg_reg;
    assign window_range   = o_range_reg;
    assign unstable       = o_unst_reg;
    assign zone           = o_zone_reg;

    // ring memories
    always_ff @(posedge clk)
    begin
        if (cmd.fill_short)
        begin
            short_mem[cmd.addr[ssdl_pkg::SHORT_AW-1:0]] <= sample_reg;
        end
        else if (cmd.upd_short)
        begin
            short_mem[short_pos_reg] <= new_slot;
        end
        if (cmd.rd_short)
        begin
            short_q_reg <= short_mem[short_pos_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            win_mem[cmd.addr] <= sample_reg;
        end
        else if (cmd.wr_win)
        begin
            win_mem[win_pos_reg] <= avg;
        end
        if (cmd.scan_rd)
        begin
            win_q_reg <= win_mem[cmd.addr];
        end
    end

    // zone decision
    always_comb
    begin
        mid_steps_next = mid_steps_reg;
        deep_next      = deep_reg;
        pend_up_next   = pend_up_reg;
        pend_dn_next   = pend_dn_reg;
        duty_next      = duty_reg;
        zone_next      = ssdl_pkg::ZONE_NONE;
        if ({1'b0, avg} >= high_thr)
        begin
            zone_next      = ssdl_pkg::ZONE_HIGH;
            mid_steps_next = '0;
            deep_next      = 1'b0;
            if (unst)
            begin
                if (duty_reg > duty_floor_mid_reg)
                begin
                    duty_next = duty_reg - 1'b1;
                end
                else
                begin
                    duty_next = duty_floor_mid_reg;
                end
            end
            else if (pend_up_reg)
            begin
                pend_up_next = 1'b0;
                if (duty_reg < duty_full_reg)
                begin
                    duty_next = duty_reg + 1'b1;
                end
            end
        end
        else if (avg > low_level_reg &&
                 (avg <= nominal_level_reg || mid_steps_reg == ssdl_pkg::MID_STEPS_MAX))
        begin
            zone_next = ssdl_pkg::ZONE_MID;
            if (pend_dn_reg)
            begin
                pend_dn_next = 1'b0;
                deep_next    = 1'b0;
                if (mid_steps_reg < ssdl_pkg::MID_STEPS_MAX)
                begin
                    mid_steps_next = mid_steps_reg + 1'b1;
                end
                if (duty_reg > duty_floor_mid_reg)
                begin
                    duty_next = duty_m2;
                end
                else if (duty_reg < duty_floor_mid_reg)
                begin
                    duty_next = duty_reg + 1'b1;
                end
            end
        end
        else if (avg <= low_level_reg || deep_reg)
        begin
            zone_next = ssdl_pkg::ZONE_DEEP;
            if (pend_dn_reg)
            begin
                pend_dn_next   = 1'b0;
                deep_next      = 1'b1;
                mid_steps_next = '0;
                duty_next      = (duty_reg > duty_floor_low_reg) ? duty_m2 : duty_floor_low_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= sample;
        end
        if (cmd.wr_win)
        begin
            max_reg <= '0;
            min_reg <= '1;
        end
        else if (cmd.scan_acc)
        begin
            if (win_q_reg > max_reg)
            begin
                max_reg <= win_q_reg;
            end
            if (win_q_reg < min_reg)
            begin
                min_reg <= win_q_reg;
            end
        end
        if (cmd.fill)
        begin
            sum_reg <= {sample_reg, ssdl_pkg::SHORT_AW'(0)};
        end
        else if (cmd.upd_short)
        begin
            sum_reg <= sum_reg - ssdl_pkg::SUM_W'(short_q_reg) + ssdl_pkg::SUM_W'(new_slot);
        end
        if (cmd.decide)
        begin
            o_duty_reg  <= duty_next;
            o_avg_reg   <= avg;
            o_range_reg <= range_v;
            o_unst_reg  <= unst;
            o_zone_reg  <= zone_next;
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unstable_range_reg <= SB'(200);
            nominal_level_reg  <= SB'(2000);
            dead_zone_reg      <= SB'(50);
            low_level_reg      <= SB'(1800);
            duty_floor_low_reg <= DW'(300);
            duty_floor_mid_reg <= DW'(500);
            duty_full_reg      <= DW'(1000);
            primed_reg         <= 1'b0;
            short_pos_reg      <= '0;
            win_pos_reg        <= '0;
            mid_steps_reg      <= '0;
            deep_reg           <= 1'b0;
            pend_up_reg        <= 1'b0;
            pend_dn_reg        <= 1'b0;
            duty_reg           <= DW'(1000);
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ssdl_pkg::REG_UNSTABLE_RANGE: unstable_range_reg <= cfg_data[SB-1:0];
                    ssdl_pkg::REG_NOMINAL_LEVEL:  nominal_level_reg  <= cfg_data[SB-1:0];
                    ssdl_pkg::REG_DEAD_ZONE:      dead_zone_reg      <= cfg_data[SB-1:0];
                    ssdl_pkg::REG_LOW_LEVEL:      low_level_reg      <= cfg_data[SB-1:0];
                    ssdl_pkg::REG_DUTY_FLOOR_LOW: duty_floor_low_reg <= cfg_data;
                    ssdl_pkg::REG_DUTY_FLOOR_MID: duty_floor_mid_reg <= cfg_data;
                    ssdl_pkg::REG_DUTY_FULL:      duty_full_reg      <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            // latch tick flags on accept, consume them on a decision whose zone acts on them
            if (cmd.load)
            begin
                pend_up_reg <= pend_up_reg | add_tick;
                pend_dn_reg <= pend_dn_reg | sub_tick;
            end
            else if (cmd.decide)
            begin
                pend_up_reg   <= pend_up_next;
                pend_dn_reg   <= pend_dn_next;
                mid_steps_reg <= mid_steps_next;
                deep_reg      <= deep_next;
                duty_reg      <= duty_next;
            end
            if (cmd.fill)
            begin
                primed_reg <= 1'b1;
            end
            if (cmd.upd_short)
            begin
                short_pos_reg <= short_pos_reg + 1'b1;
            end
            if (cmd.wr_win)
            begin
                win_pos_reg <= win_pos_reg + 1'b1;
            end
            // hold result until taken
            if (cmd.decide)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[src/ssdl_checker.sv]
`default_nettype none
module ssdl_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        in_valid,
    input wire        in_stall,
    input wire        out_valid,
    input wire        out_stall,
    input wire [15:0] duty_limit,
    input wire [11:0] window_range,
    input wire        unstable
);

    // a stalled result stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result holds its duty value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(duty_limit))
        else $error("duty changed while stalled");

    // busy after an accepted transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("next transaction taken too early");

    // flat window is never unstable
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_range == 12'd0 |-> !unstable)
        else $error("unstable flagged with zero range");

endmodule

bind supply_sag_duty_limiter ssdl_checker u_ssdl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .duty_limit   (duty_limit),
    .window_range (window_range),
    .unstable     (unstable)
);
`default_nettype wire
